// File: hw/rtl/pcrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrd_pkg
// Types, widths and helpers shared by the primary ray generation pipeline.
// ----------------------------------------------------------------------------
package pcrd_pkg;

  localparam int COMP_W  = 16;               // packed vector component width
  localparam int AXIS_W  = 32;               // right / up axis width
  localparam int SCR_W   = 16;               // screen coordinate width
  localparam int SCALE_W = 16;               // Q4.12 scale
  localparam int CFG_W   = 3 * COMP_W;       // config data width
  localparam int CIDX_W  = 8;                // config index width
  localparam int OFS_W   = SCR_W + SCALE_W + 1 - 15;  // screen offset, Q.13
  localparam int PROD_W  = AXIS_W + OFS_W;
  localparam int T_W     = PROD_W - 13 + 2;  // unnormalized direction component
  localparam int MAG_W   = T_W;
  localparam int POS_W   = 6;
  localparam int NORM_MSB = 29;              // largest normalized magnitude in [2^29, 2^30)
  localparam int NMAG_W  = NORM_MSB + 1;
  localparam int SQ_W    = 2 * NMAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int QUO_W   = 15;
  localparam int NUM_W   = NMAG_W + QUO_W;
  localparam int DIR_W   = 16;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = QUO_W;

  typedef enum logic [CIDX_W-1:0] {
    REG_EYE   = 8'd0,
    REG_FWD   = 8'd1,
    REG_REFUP = 8'd2,
    REG_SCALE = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                         degen;
    logic [2:0]                   neg;
    logic [2:0][NMAG_W-1:0]       mag;
  } norm_tag_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  rad;
    norm_tag_t         tag;
  } sqrt_data_t;

  typedef struct packed {
    logic                   degen;
    logic [2:0]             neg;
    logic [NUM_W-1:0]       dvs;
    logic [2:0][NUM_W-1:0]  rem;
    logic [2:0][QUO_W-1:0]  quo;
  } div_data_t;

  function automatic logic [AXIS_W-1:0] sat_axis(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (AXIS_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi[AXIS_W-1:0];
    end else if (v < lo) begin
      return lo[AXIS_W-1:0];
    end
    return v[AXIS_W-1:0];
  endfunction

endpackage

// File: hw/rtl/pcrd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrd_front
// Screen offset, axis blend, magnitude normalization and sum of squares.
// ----------------------------------------------------------------------------
module pcrd_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [pcrd_pkg::SCR_W-1:0]            screen_x,
  input  logic [pcrd_pkg::SCR_W-1:0]            screen_y,
  input  logic [pcrd_pkg::CFG_W-1:0]            fwd,
  input  logic [pcrd_pkg::SCALE_W-1:0]          scale,
  input  logic [2:0][pcrd_pkg::AXIS_W-1:0]      right_axis,
  input  logic [2:0][pcrd_pkg::AXIS_W-1:0]      up_axis,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output pcrd_pkg::sqrt_data_t                  out_data
);
  import pcrd_pkg::*;

  localparam int NST = 8;

  logic [NST-1:0] v_r;
  logic [NST:0]   go;

  logic signed [OFS_W-1:0]  ox_r, oy_r;
  logic [2:0][PROD_W-1:0]   pr_r, pu_r;
  logic [2:0][T_W-1:0]      t_r;
  logic [2:0][MAG_W-1:0]    mag3_r, mag4_r;
  logic [2:0]               neg3_r, neg4_r;
  logic [MAG_W-1:0]         mx3_r;
  logic [POS_W-1:0]         pos4_r;
  logic                     degen4_r;
  norm_tag_t                tag5_r, tag6_r, tag7_r;
  logic [2:0][SQ_W-1:0]     sq6_r;
  logic [SUM_W-1:0]         sum7_r;

  logic signed [SCR_W-1:0]   sx, sy;
  logic signed [SCR_W+SCALE_W:0] px, py;
  logic [2:0][MAG_W-1:0]     mag_c;
  logic [MAG_W-1:0]          mx_c;
  logic [POS_W-1:0]          pos_c;
  logic [2:0][NMAG_W-1:0]    nmag_c;
  logic [POS_W-1:0]          rsh, lsh;
  logic [2:0][MAG_W-1:0]     shifted;

  // a stage loads when it is empty or the next one loads too
  always_comb begin
    go[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      go[k] = !v_r[k] || go[k+1];
    end
  end
  assign in_ready = go[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (go[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (go[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // coord - 0.5 is the coordinate with its top bit flipped
  assign sx = $signed({~screen_x[SCR_W-1], screen_x[SCR_W-2:0]});
  assign sy = $signed({~screen_y[SCR_W-1], screen_y[SCR_W-2:0]});
  assign px = sx * $signed({1'b0, scale});
  assign py = sy * $signed({1'b0, scale});

  always_comb begin
    mx_c = '0;
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = t_r[i][T_W-1] ? (~t_r[i] + 1'b1) : t_r[i];
      if (mag_c[i] > mx_c) mx_c = mag_c[i];
    end
  end

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mx3_r[i]) pos_c = POS_W'(i);
    end
  end

  always_comb begin
    rsh = (pos4_r > POS_W'(NORM_MSB)) ? pos4_r - POS_W'(NORM_MSB) : '0;
    lsh = (pos4_r < POS_W'(NORM_MSB)) ? POS_W'(NORM_MSB) - pos4_r : '0;
    for (int i = 0; i < 3; i++) begin
      shifted[i] = (mag4_r[i] >> rsh) << lsh;
      nmag_c[i]  = shifted[i][NMAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      ox_r <= px[SCR_W+SCALE_W:15];
      oy_r <= py[SCR_W+SCALE_W:15];
    end
    if (go[1]) begin
      for (int i = 0; i < 3; i++) begin
        pr_r[i] <= $signed(right_axis[i]) * ox_r;
        pu_r[i] <= $signed(up_axis[i]) * oy_r;
      end
    end
    if (go[2]) begin
      for (int i = 0; i < 3; i++) begin
        t_r[i] <= T_W'($signed(fwd[i*COMP_W +: COMP_W]))
                + T_W'($signed(pr_r[i][PROD_W-1:13]))
                + T_W'($signed(pu_r[i][PROD_W-1:13]));
      end
    end
    if (go[3]) begin
      mag3_r <= mag_c;
      mx3_r  <= mx_c;
      for (int i = 0; i < 3; i++) neg3_r[i] <= t_r[i][T_W-1];
    end
    if (go[4]) begin
      mag4_r   <= mag3_r;
      neg4_r   <= neg3_r;
      pos4_r   <= pos_c;
      degen4_r <= (mx3_r == '0);
    end
    if (go[5]) begin
      tag5_r.mag   <= nmag_c;
      tag5_r.neg   <= neg4_r;
      tag5_r.degen <= degen4_r;
    end
    if (go[6]) begin
      tag6_r <= tag5_r;
      for (int i = 0; i < 3; i++) sq6_r[i] <= tag5_r.mag[i] * tag5_r.mag[i];
    end
    if (go[7]) begin
      tag7_r <= tag6_r;
      sum7_r <= SUM_W'(sq6_r[0]) + SUM_W'(sq6_r[1]) + SUM_W'(sq6_r[2]);
    end
  end

  assign out_valid     = v_r[NST-1];
  assign out_data.rem  = '0;
  assign out_data.root = '0;
  assign out_data.rad  = sum7_r;
  assign out_data.tag  = tag7_r;

endmodule

// File: hw/rtl/pcrd_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrd_sqrt_cell
// One digit step of the square root: takes two radicand bits, yields one root bit.
// ----------------------------------------------------------------------------
module pcrd_sqrt_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pcrd_pkg::sqrt_data_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pcrd_pkg::sqrt_data_t out_data
);
  import pcrd_pkg::*;

  logic        v_r;
  sqrt_data_t  d_r, d_nxt;
  logic [REM_W-1:0] r2, trial;
  logic        ge;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    r2    = {in_data.rem[REM_W-3:0], in_data.rad[SUM_W-1 -: 2]};
    trial = REM_W'({in_data.root, 2'b01});
    ge    = (r2 >= trial);
    d_nxt      = in_data;
    d_nxt.rem  = ge ? r2 - trial : r2;
    d_nxt.root = {in_data.root[ROOT_W-2:0], ge};
    d_nxt.rad  = in_data.rad << 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) d_r <= d_nxt;
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

// File: hw/rtl/pcrd_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrd_div_cell
// One restoring quotient bit for each of the three direction lanes.
// ----------------------------------------------------------------------------
module pcrd_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcrd_pkg::div_data_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pcrd_pkg::div_data_t out_data
);
  import pcrd_pkg::*;

  logic       v_r;
  div_data_t  d_r, d_nxt;
  logic [2:0] ge;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    d_nxt = in_data;
    for (int i = 0; i < 3; i++) begin
      ge[i]         = (in_data.rem[i] >= in_data.dvs);
      d_nxt.rem[i]  = ge[i] ? in_data.rem[i] - in_data.dvs : in_data.rem[i];
      d_nxt.quo[i]  = {in_data.quo[i][QUO_W-2:0], ge[i]};
    end
    d_nxt.dvs = in_data.dvs >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) d_r <= d_nxt;
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

// File: hw/rtl/pinhole_camera_ray_direction_unit.sv
`timescale 1ns / 1ps
// stages from input item to result: 8 front stages, 31 root cells, one divider
// set-up stage, 15 divider cells; one item per cycle sustained while out_tready is high and input is not held off
// every stage and cell holds one item, ready runs back through the whole chain
// reset and every config write hold off input items while the right and up axes
// are rebuilt from the new registers
// ----------------------------------------------------------------------------
// pinhole_camera_ray_direction_unit
// Primary ray generation: eye origin and normalized view direction per item.
// ----------------------------------------------------------------------------
module pinhole_camera_ray_direction_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // screen_x, screen_y
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [95:0]                   out_tdata,  // origin_x/y/z, dir_x/y/z
  output logic [0:0]                    out_tuser,  // degenerate
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcrd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [pcrd_pkg::CFG_W-1:0]    cfg_data
);
  import pcrd_pkg::*;

  logic [CFG_W-1:0]   eye_r, fwd_r, rup_r;
  logic [SCALE_W-1:0] scale_r;
  logic [1:0]         settle_r;
  logic [2:0][AXIS_W-1:0] right_r, up_r, right_nxt, up_nxt;

  logic signed [COMP_W-1:0]   f [3];
  logic signed [COMP_W-1:0]   u [3];
  logic signed [AXIS_W-1:0]   ra [3];
  logic signed [2*COMP_W:0]   rx [3];
  logic signed [AXIS_W+COMP_W:0] ux [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_r    <= '0;
      fwd_r    <= '0;
      rup_r    <= '0;
      scale_r  <= SCALE_W'(4096);
      settle_r <= 2'd3;
    end else begin
      if (cfg_valid && cfg_ready) begin
        settle_r <= 2'd3;
        unique case (cfg_index)
          REG_EYE:   eye_r   <= cfg_data;
          REG_FWD:   fwd_r   <= cfg_data;
          REG_REFUP: rup_r   <= cfg_data;
          REG_SCALE: scale_r <= cfg_data[SCALE_W-1:0];
          default:   ;
        endcase
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  // axes follow the config registers: right_r is registered from fwd and ref-up, then up_r from right_r
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f[i]  = $signed(fwd_r[i*COMP_W +: COMP_W]);
      u[i]  = $signed(rup_r[i*COMP_W +: COMP_W]);
      ra[i] = $signed(right_r[i]);
    end
    rx[0] = f[1] * u[2] - f[2] * u[1];
    rx[1] = f[2] * u[0] - f[0] * u[2];
    rx[2] = f[0] * u[1] - f[1] * u[0];
    ux[0] = ra[1] * f[2] - ra[2] * f[1];
    ux[1] = ra[2] * f[0] - ra[0] * f[2];
    ux[2] = ra[0] * f[1] - ra[1] * f[0];
    for (int i = 0; i < 3; i++) begin
      right_nxt[i] = sat_axis(64'(rx[i] >>> 13));
      up_nxt[i]    = sat_axis(64'(ux[i] >>> 13));
    end
  end

  always_ff @(posedge clk) begin
    right_r <= right_nxt;
    up_r    <= up_nxt;
  end

  logic       fr_in_ready, fr_valid, fr_ready;
  sqrt_data_t fr_data;

  assign in_tready = fr_in_ready && (settle_r == 2'd0);

  pcrd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid && (settle_r == 2'd0)),
    .in_ready   (fr_in_ready),
    .screen_x   (in_tdata[15:0]),
    .screen_y   (in_tdata[31:16]),
    .fwd        (fwd_r),
    .scale      (scale_r),
    .right_axis (right_r),
    .up_axis    (up_r),
    .out_valid  (fr_valid),
    .out_ready  (fr_ready),
    .out_data   (fr_data)
  );

  logic       sq_v   [SQRT_STEPS+1];
  logic       sq_rdy [SQRT_STEPS+1];
  sqrt_data_t sq_d   [SQRT_STEPS+1];

  assign sq_v[0]  = fr_valid;
  assign sq_d[0]  = fr_data;
  assign fr_ready = sq_rdy[0];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    pcrd_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[k]),
      .in_ready  (sq_rdy[k]),
      .in_data   (sq_d[k]),
      .out_valid (sq_v[k+1]),
      .out_ready (sq_rdy[k+1]),
      .out_data  (sq_d[k+1])
    );
  end

  // divider set-up: numerator mag*2^14 + len/2, divisor len aligned to the top
  logic      prep_v_r;
  div_data_t prep_r;
  logic      dv_v   [DIV_STEPS+1];
  logic      dv_rdy [DIV_STEPS+1];
  div_data_t dv_d   [DIV_STEPS+1];
  logic [ROOT_W-1:0] len;

  assign len                 = sq_d[SQRT_STEPS].root;
  assign sq_rdy[SQRT_STEPS]  = !prep_v_r || dv_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_v_r <= 1'b0;
    end else if (sq_rdy[SQRT_STEPS]) begin
      prep_v_r <= sq_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (sq_rdy[SQRT_STEPS]) begin
      prep_r.degen <= sq_d[SQRT_STEPS].tag.degen;
      prep_r.neg   <= sq_d[SQRT_STEPS].tag.neg;
      prep_r.dvs   <= NUM_W'({len, {(QUO_W-1){1'b0}}});
      for (int i = 0; i < 3; i++) begin
        prep_r.rem[i] <= NUM_W'({sq_d[SQRT_STEPS].tag.mag[i], {(QUO_W-1){1'b0}}})
                       + NUM_W'(len >> 1);
        prep_r.quo[i] <= '0;
      end
    end
  end

  assign dv_v[0] = prep_v_r;
  assign dv_d[0] = prep_r;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    pcrd_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_v[k]),
      .in_ready  (dv_rdy[k]),
      .in_data   (dv_d[k]),
      .out_valid (dv_v[k+1]),
      .out_ready (dv_rdy[k+1]),
      .out_data  (dv_d[k+1])
    );
  end

  logic [2:0][DIR_W-1:0] dir;
  div_data_t             fin;

  assign fin                = dv_d[DIV_STEPS];
  assign dv_rdy[DIV_STEPS]  = out_tready;
  assign out_tvalid         = dv_v[DIV_STEPS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (fin.degen) begin
        dir[i] = '0;
      end else if (fin.neg[i]) begin
        dir[i] = -DIR_W'(fin.quo[i]);
      end else begin
        dir[i] = DIR_W'(fin.quo[i]);
      end
    end
  end

  assign out_tdata = {dir[2], dir[1], dir[0], eye_r};
  assign out_tuser = fin.degen;

`ifndef SYNTH
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[95:48] == '0)
    else $error("degenerate ray with nonzero direction");

  a_dir_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[63:48]) <= 16'sd16384
                && $signed(out_tdata[63:48]) >= -16'sd16384
                && $signed(out_tdata[79:64]) <= 16'sd16384
                && $signed(out_tdata[79:64]) >= -16'sd16384
                && $signed(out_tdata[95:80]) <= 16'sd16384
                && $signed(out_tdata[95:80]) >= -16'sd16384)
    else $error("direction component out of unit range");

  a_cfg_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_tready ##1 !in_tready)
    else $error("input taken before axes settled");
`endif

endmodule
